// File: rtl/core/utf8tf_pkg.sv
package utf8tf_pkg;

  // Default depth of the queue between the decoder and the output stage, in groups.
  localparam int unsigned QUEUE_DEPTH = 4;

  // Reset value of the output capacity register.
  localparam logic [15:0] CAP_RESET = 16'd512;

  // Code point range of the kept CJK ideographs.
  localparam logic [20:0] CJK_LO = 21'h004E00;
  localparam logic [20:0] CJK_HI = 21'h009FFF;

  // Lead byte masks and patterns.
  localparam logic [7:0] LEAD2_MASK = 8'hE0;
  localparam logic [7:0] LEAD2_PAT  = 8'hC0;
  localparam logic [7:0] LEAD3_MASK = 8'hF0;
  localparam logic [7:0] LEAD3_PAT  = 8'hE0;
  localparam logic [7:0] LEAD4_MASK = 8'hF8;
  localparam logic [7:0] LEAD4_PAT  = 8'hF0;

  // All results caused by one request: up to four bytes, or one bare end marker.
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      count;
    logic            has_byte;
    logic            eot;
  } group_t;

  // Sequence length given by a lead byte; zero for a byte that cannot start one.
  function automatic logic [2:0] lead_len(logic [7:0] b);
    if (b[7] == 1'b0) begin
      return 3'd1;
    end else if ((b & LEAD2_MASK) == LEAD2_PAT) begin
      return 3'd2;
    end else if ((b & LEAD3_MASK) == LEAD3_PAT) begin
      return 3'd3;
    end else if ((b & LEAD4_MASK) == LEAD4_PAT) begin
      return 3'd4;
    end
    return 3'd0;
  endfunction

  // Code point of a sequence of len bytes; following bytes give their low six bits.
  function automatic logic [20:0] code_point(logic [7:0] b0, logic [7:0] b1,
                                             logic [7:0] b2, logic [7:0] b3,
                                             logic [2:0] len);
    logic [20:0] cp;
    case (len)
      3'd1:    cp = {13'd0, b0};
      3'd2:    cp = {10'd0, b0[4:0], b1[5:0]};
      3'd3:    cp = {5'd0, b0[3:0], b1[5:0], b2[5:0]};
      default: cp = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
    endcase
    return cp;
  endfunction

  // Ideographs, ASCII digits, letters and space are kept.
  function automatic logic is_kept(logic [20:0] cp);
    return (cp >= CJK_LO && cp <= CJK_HI) ||
           (cp >= 21'h30 && cp <= 21'h39) ||
           (cp >= 21'h61 && cp <= 21'h7A) ||
           (cp >= 21'h41 && cp <= 21'h5A) ||
           (cp == 21'h20);
  endfunction

  // No further sequence may start once bytes_written + 1 reaches the capacity.
  function automatic logic no_room(logic [15:0] bw, logic [15:0] cap);
    return ({1'b0, bw} + 17'd1) >= {1'b0, cap};
  endfunction

  // A kept sequence of len bytes still fits below the capacity.
  function automatic logic fits(logic [15:0] bw, logic [2:0] len, logic [15:0] cap);
    return ({1'b0, bw} + {14'd0, len}) < {1'b0, cap};
  endfunction

endpackage

// File: rtl/core/utf8tf_in_if.sv
interface utf8tf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

// File: rtl/core/utf8tf_out_if.sv
interface utf8tf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       has_byte;
  logic       end_of_text;

  modport source (output valid, output out_byte, output has_byte, output end_of_text,
                  input ready);
  modport sink   (input valid, input out_byte, input has_byte, input end_of_text,
                  output ready);
endinterface

// File: rtl/core/utf8tf_cfg_if.sv
interface utf8tf_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] output_capacity;

  modport source (output valid, output output_capacity, input ready);
  modport sink   (input valid, input output_capacity, output ready);
endinterface

// File: rtl/core/utf8tf_fifo.sv
module utf8tf_fifo #(
  parameter int unsigned DEPTH = utf8tf_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  utf8tf_pkg::group_t  push_data,
  output logic                full,
  input  logic                pop,
  output utf8tf_pkg::group_t  pop_data,
  output logic                empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  utf8tf_pkg::group_t mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r;
  logic [PTR_W-1:0]   rd_ptr_r;
  logic [CNT_W-1:0]   count_r;
  logic [PTR_W-1:0]   wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_nxt;
  logic [CNT_W-1:0]   count_nxt;

  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = mem_r[rd_ptr_r];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full && !pop))
    else $error("group queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && empty))
    else $error("group queue read while empty");

endmodule

// File: rtl/core/utf8tf_front.sv
module utf8tf_front (
  input  logic               clk,
  input  logic               rst_n,
  utf8tf_in_if.sink          in_port,
  utf8tf_cfg_if.sink         cfg_port,
  input  logic               queue_full,
  output logic               push,
  output utf8tf_pkg::group_t push_data
);

  logic [7:0]  hld_r [3];
  logic [1:0]  cnt_r;
  logic [15:0] bw_r;
  logic        full_r;
  logic [15:0] cap_r;

  logic [7:0]      hld_nxt [3];
  logic [1:0]      cnt_nxt;
  logic [15:0]     bw_nxt;
  logic            full_nxt;
  logic            acc;
  logic            ended;
  logic [7:0]      b;
  logic [2:0]      ld;
  logic [2:0]      slen;
  logic [7:0]      s1;
  logic [7:0]      s2;
  logic [7:0]      s3;
  logic [7:0]      r0;
  logic [7:0]      r1;
  logic [2:0]      l0;
  logic [15:0]     bw1;
  logic            two_rest;
  logic            go_second;
  logic [3:0][7:0] ob;
  logic [2:0]      oc;

  assign in_port.ready  = !queue_full;
  assign cfg_port.ready = 1'b1;
  assign acc   = in_port.valid && in_port.ready;
  assign b     = in_port.in_byte;
  assign ended = (b == 8'd0) || in_port.in_last;

  // Decode one request: feed the byte, then on text end flush what is held.
  always_comb begin
    hld_nxt   = hld_r;
    cnt_nxt   = cnt_r;
    bw_nxt    = bw_r;
    full_nxt  = full_r;
    ob        = '0;
    oc        = 3'd0;
    ld        = utf8tf_pkg::lead_len(b);
    slen      = {1'b0, cnt_r} + 3'd1;
    s1        = (cnt_r >= 2'd2) ? hld_r[1] : b;
    s2        = (cnt_r == 2'd3) ? hld_r[2] : ((cnt_r == 2'd2) ? b : 8'd0);
    s3        = (cnt_r == 2'd3) ? b : 8'd0;
    r0        = 8'd0;
    r1        = 8'd0;
    l0        = 3'd0;
    bw1       = bw_r;
    two_rest  = 1'b0;
    go_second = 1'b0;

    // Feed a nonzero byte.
    if (acc && b != 8'd0 && !full_r) begin
      if (cnt_r == 2'd0) begin
        if (utf8tf_pkg::no_room(bw_r, cap_r)) begin
          full_nxt = 1'b1;
        end else if (ld == 3'd1) begin
          if (utf8tf_pkg::is_kept(utf8tf_pkg::code_point(b, 8'd0, 8'd0, 8'd0, 3'd1)) &&
              utf8tf_pkg::fits(bw_r, 3'd1, cap_r)) begin
            ob[0]  = b;
            oc     = 3'd1;
            bw_nxt = bw_r + 16'd1;
          end
        end else if (ld != 3'd0) begin
          hld_nxt[0] = b;
          cnt_nxt    = 2'd1;
        end
      end else if (slen >= utf8tf_pkg::lead_len(hld_r[0]) || cnt_r == 2'd3) begin
        // The sequence is complete with this byte.
        if (utf8tf_pkg::is_kept(utf8tf_pkg::code_point(hld_r[0], s1, s2, s3, slen)) &&
            utf8tf_pkg::fits(bw_r, slen, cap_r)) begin
          ob     = {s3, s2, s1, hld_r[0]};
          oc     = slen;
          bw_nxt = bw_r + {13'd0, slen};
        end
        cnt_nxt = 2'd0;
      end else begin
        hld_nxt[cnt_r] = b;
        cnt_nxt        = cnt_r + 2'd1;
      end
    end

    // Text end: drop the lead byte and parse the held rest again.
    if (acc && ended) begin
      r0       = hld_nxt[1];
      r1       = hld_nxt[2];
      two_rest = (cnt_nxt == 2'd3);
      l0       = utf8tf_pkg::lead_len(r0);
      bw1      = bw_nxt;
      if (cnt_nxt > 2'd1 && !utf8tf_pkg::no_room(bw_nxt, cap_r)) begin
        if (l0 == 3'd1) begin
          if (utf8tf_pkg::is_kept(utf8tf_pkg::code_point(r0, 8'd0, 8'd0, 8'd0, 3'd1)) &&
              utf8tf_pkg::fits(bw_nxt, 3'd1, cap_r)) begin
            ob[0] = r0;
            oc    = 3'd1;
            bw1   = bw_nxt + 16'd1;
          end
          go_second = two_rest;
        end else if (l0 == 3'd2 && two_rest) begin
          if (utf8tf_pkg::is_kept(utf8tf_pkg::code_point(r0, r1, 8'd0, 8'd0, 3'd2)) &&
              utf8tf_pkg::fits(bw_nxt, 3'd2, cap_r)) begin
            ob[0] = r0;
            ob[1] = r1;
            oc    = 3'd2;
          end
        end else begin
          go_second = two_rest;
        end
        if (go_second && !utf8tf_pkg::no_room(bw1, cap_r) &&
            utf8tf_pkg::lead_len(r1) == 3'd1 &&
            utf8tf_pkg::is_kept(utf8tf_pkg::code_point(r1, 8'd0, 8'd0, 8'd0, 3'd1)) &&
            utf8tf_pkg::fits(bw1, 3'd1, cap_r)) begin
          ob[oc[1:0]] = r1;
          oc          = oc + 3'd1;
        end
      end
      hld_nxt[0] = 8'd0;
      hld_nxt[1] = 8'd0;
      hld_nxt[2] = 8'd0;
      cnt_nxt    = 2'd0;
      bw_nxt     = 16'd0;
      full_nxt   = 1'b0;
    end
  end

  // Result group handed to the queue; an end with no byte becomes a bare marker.
  always_comb begin
    push               = acc && (oc != 3'd0 || ended);
    push_data.bytes    = ob;
    push_data.count    = (oc == 3'd0) ? 3'd1 : oc;
    push_data.has_byte = (oc != 3'd0);
    push_data.eot      = ended;
  end

  // Text state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hld_r[0] <= 8'd0;
      hld_r[1] <= 8'd0;
      hld_r[2] <= 8'd0;
      cnt_r    <= 2'd0;
      bw_r     <= 16'd0;
      full_r   <= 1'b0;
    end else begin
      hld_r  <= hld_nxt;
      cnt_r  <= cnt_nxt;
      bw_r   <= bw_nxt;
      full_r <= full_nxt;
    end
  end

  // Capacity register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= utf8tf_pkg::CAP_RESET;
    end else if (cfg_port.valid && cfg_port.ready) begin
      cap_r <= cfg_port.output_capacity;
    end
  end

  a_full_not_holding: assert property (@(posedge clk) disable iff (!rst_n)
    full_r |-> (cnt_r == 2'd0))
    else $error("buffer full while a sequence is held");

  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && ended) |=> (cnt_r == 2'd0 && bw_r == 16'd0 && !full_r))
    else $error("text state not cleared after end of text");

endmodule

// File: rtl/core/utf8tf_back.sv
module utf8tf_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               queue_empty,
  input  utf8tf_pkg::group_t pop_data,
  output logic               pop,
  utf8tf_out_if.source       out_port
);

  utf8tf_pkg::group_t cur_r;
  logic               vld_r;
  logic [1:0]         idx_r;
  logic [2:0]         cnt_m1;
  logic               last;
  logic               out_acc;

  assign cnt_m1  = cur_r.count - 3'd1;
  assign last    = ({1'b0, idx_r} == cnt_m1);
  assign out_acc = vld_r && out_port.ready;
  assign pop     = !queue_empty && (!vld_r || (out_acc && last));

  // Present the current result from the held group.
  assign out_port.valid       = vld_r;
  assign out_port.out_byte    = cur_r.bytes[idx_r];
  assign out_port.has_byte    = cur_r.has_byte;
  assign out_port.end_of_text = cur_r.eot && last;

  // Step through the group, loading the next one as the last result goes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      idx_r <= 2'd0;
    end else if (pop) begin
      vld_r <= 1'b1;
      idx_r <= 2'd0;
    end else if (out_acc) begin
      if (last) begin
        vld_r <= 1'b0;
      end else begin
        idx_r <= idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_r <= pop_data;
    end
  end

  a_bare_marker_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r && !cur_r.has_byte) |-> (cur_r.eot && cur_r.count == 3'd1))
    else $error("bare marker that does not end the text");

  a_group_continues: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && !last) |=> (vld_r && idx_r == $past(idx_r) + 2'd1))
    else $error("group left before its last result");

endmodule

// File: rtl/core/utf8_text_filter_core.sv
// UTF-8 text filter. Text bytes enter on in_port at up to one request per clock; each
// sequence is decoded from its lead byte and passed through whole when its code point is
// a CJK ideograph (U+4E00..U+9FFF), an ASCII digit or letter, or a space and still fits
// below the capacity; anything else is dropped. A zero byte or in_last ends the text, and the
// last result of every text carries end_of_text (a bare marker with has_byte low if nothing
// is passed at that point). The decoder takes one byte per cycle and puts all results of
// that byte into a queue of QUEUE_DEPTH groups; the output stage drains the queue at one
// result per cycle while out_port.ready is high, so a byte that completes a sequence of n
// kept bytes gives n results in turn, and in_port.ready drops only while the queue is full.
// The capacity register (cfg_port, always ready) should be written between texts.
module utf8_text_filter_core #(
  parameter int unsigned QUEUE_DEPTH = utf8tf_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst_n,
  utf8tf_in_if.sink     in_port,
  utf8tf_cfg_if.sink    cfg_port,
  utf8tf_out_if.source  out_port
);

  utf8tf_pkg::group_t push_data;
  utf8tf_pkg::group_t pop_data;
  logic               push;
  logic               pop;
  logic               queue_full;
  logic               queue_empty;

  // Decoder and classifier.
  utf8tf_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_port    (in_port),
    .cfg_port   (cfg_port),
    .queue_full (queue_full),
    .push       (push),
    .push_data  (push_data)
  );

  // Result group queue.
  utf8tf_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (queue_full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (queue_empty)
  );

  // Output serializer.
  utf8tf_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .queue_empty (queue_empty),
    .pop_data    (pop_data),
    .pop         (pop),
    .out_port    (out_port)
  );

endmodule

// File: verif/utf8_text_filter_core_tb.sv
`timescale 1ns / 1ps

module utf8_text_filter_core_tb;

  localparam int HOLD_CYCLES   = 60;
  localparam int SETTLE_CYCLES = 10;
  localparam int DRAIN_LIMIT   = 20000;

  // One filtered result as it leaves the block.
  typedef struct packed {
    logic [7:0] data;
    logic       has_byte;
    logic       eot;
  } result_t;

  logic clk;
  logic rst_n;

  utf8tf_in_if  in_if ();
  utf8tf_cfg_if cfg_if ();
  utf8tf_out_if out_if ();

  utf8_text_filter_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_port  (in_if),
    .cfg_port (cfg_if),
    .out_port (out_if)
  );

  // Idle and stall rates in percent, and the long receiver hold-off.
  int send_idle;
  int recv_stall;
  int hold_asked;
  int hold_served;
  int hold_left;
  int mismatches;

  // Filter state as the predictor sees it.
  logic [15:0] capacity;
  logic [7:0]  held [3];
  int          held_n;
  int          written;
  bit          text_full;

  result_t    step_results [$];
  result_t    due_results [$];
  logic [7:0] text_bytes [$];
  result_t    seen_result;
  result_t    due_result;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Sequence length from a lead byte; zero for a byte that cannot start one.
  function automatic int seq_bytes(logic [7:0] b);
    if (!b[7]) return 1;
    if (b[7:5] == 3'b110) return 2;
    if (b[7:4] == 4'b1110) return 3;
    if (b[7:3] == 5'b11110) return 4;
    return 0;
  endfunction

  task automatic push_result(input logic [7:0] d, input logic has);
    result_t r;
    r.data = d;
    r.has_byte = has;
    r.eot = 1'b0;
    if (step_results.size() < 4) step_results.push_back(r);
  endtask

  // Pass a decoded sequence through when its code point is kept and it still fits.
  task automatic emit_seq(input logic [7:0] b0, input logic [7:0] b1,
                          input logic [7:0] b2, input logic [7:0] b3, input int n);
    logic [7:0]  s [4];
    int unsigned cp;
    bit          keep;
    s[0] = b0;
    s[1] = b1;
    s[2] = b2;
    s[3] = b3;
    case (n)
      1: cp = {24'd0, b0};
      2: cp = {21'd0, b0[4:0], b1[5:0]};
      3: cp = {16'd0, b0[3:0], b1[5:0], b2[5:0]};
      default: cp = {11'd0, b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
    endcase
    // Ideographs, digits, lower and upper case letters, and space.
    keep = (cp >= 'h4E00 && cp <= 'h9FFF) || (cp >= 'h30 && cp <= 'h39) ||
           (cp >= 'h61 && cp <= 'h7A) || (cp >= 'h41 && cp <= 'h5A) || (cp == 'h20);
    if (keep && (written + n < capacity)) begin
      for (int i = 0; i < n; i++) push_result(s[i], 1'b1);
      written += n;
    end
  endtask

  // Take one text byte into the decoder.
  task automatic feed_byte(input logic [7:0] b);
    int n;
    if (text_full) return;
    if (held_n == 0) begin
      if (written + 1 >= capacity) begin
        text_full = 1'b1;
        return;
      end
      n = seq_bytes(b);
      if (n == 0) return;
      if (n == 1) begin
        emit_seq(b, 8'h00, 8'h00, 8'h00, 1);
        return;
      end
      held[0] = b;
      held_n = 1;
      return;
    end
    n = seq_bytes(held[0]);
    if (held_n + 1 >= n || held_n >= 3) begin
      case (held_n)
        1: emit_seq(held[0], b, 8'h00, 8'h00, 2);
        2: emit_seq(held[0], held[1], b, 8'h00, 3);
        default: emit_seq(held[0], held[1], held[2], b, 4);
      endcase
      held_n = 0;
    end else begin
      held[held_n] = b;
      held_n++;
    end
  endtask

  // At the end of a text the lead byte is dropped and the held bytes are decoded again.
  task automatic flush_held();
    logic [7:0] rest [2];
    int n;
    int i;
    int len;
    n = 0;
    i = 0;
    rest[0] = 8'h00;
    rest[1] = 8'h00;
    if (held_n > 1) begin
      rest[0] = held[1];
      n = 1;
      if (held_n > 2) begin
        rest[1] = held[2];
        n = 2;
      end
    end
    held_n = 0;
    while (i < n) begin
      if (written + 1 >= capacity) begin
        text_full = 1'b1;
        break;
      end
      len = seq_bytes(rest[i]);
      if (len == 0 || i + len > n) begin
        i++;
        continue;
      end
      emit_seq(rest[i], (i + 1 < n) ? rest[i + 1] : 8'h00, 8'h00, 8'h00, len);
      i += len;
    end
  endtask

  // Work out every result caused by one accepted request.
  task automatic filter_byte(input logic [7:0] b, input logic is_last);
    bit ended;
    step_results.delete();
    ended = (b == 8'h00) || is_last;
    if (b != 8'h00) feed_byte(b);
    if (ended) begin
      flush_held();
      if (step_results.size() == 0) push_result(8'h00, 1'b0);
      step_results[step_results.size() - 1].eot = 1'b1;
      held[0] = 8'h00;
      held[1] = 8'h00;
      held[2] = 8'h00;
      held_n = 0;
      written = 0;
      text_full = 1'b0;
    end
    foreach (step_results[k]) due_results.push_back(step_results[k]);
  endtask

  // Offer one text byte, idling first at the current rate, and predict once accepted.
  task automatic send_byte(input logic [7:0] b, input logic is_last);
    while ($urandom_range(0, 99) < send_idle) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid   <= 1'b1;
    in_if.in_byte <= b;
    in_if.in_last <= is_last;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    filter_byte(b, is_last);
  endtask

  // Send the built text, ended either by the last flag or by a trailing zero byte.
  task automatic send_text(input bit zero_end);
    int n;
    n = text_bytes.size();
    for (int i = 0; i < n; i++) send_byte(text_bytes[i], (i == n - 1) && !zero_end);
    if (zero_end) send_byte(8'h00, 1'($urandom_range(0, 1)));
  endtask

  // Wait until every expected result is out, then let the block settle.
  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [15:0] v);
    wait_idle();
    cfg_if.valid           <= 1'b1;
    cfg_if.output_capacity <= v;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
    capacity = v;
  endtask

  task automatic push_cjk(input int unsigned cp);
    text_bytes.push_back({4'hE, cp[15:12]});
    text_bytes.push_back({2'b10, cp[11:6]});
    text_bytes.push_back({2'b10, cp[5:0]});
  endtask

  // Append one random token: mostly well-formed sequences, some broken ones and noise.
  task automatic add_token();
    int          pick;
    int          n;
    int unsigned cp;
    logic [7:0]  lead;
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      case ($urandom_range(0, 3))
        0: text_bytes.push_back(8'('h30 + $urandom_range(0, 9)));
        1: text_bytes.push_back(8'('h61 + $urandom_range(0, 25)));
        2: text_bytes.push_back(8'('h41 + $urandom_range(0, 25)));
        default: text_bytes.push_back(8'h20);
      endcase
    end else if (pick < 40) begin
      text_bytes.push_back(8'($urandom_range(1, 127)));
    end else if (pick < 60) begin
      // Ideographs, with the range edges and their neighbors now and then.
      case ($urandom_range(0, 9))
        0: cp = 'h4DFF;
        1: cp = 'h4E00;
        2: cp = 'h9FFF;
        3: cp = 'hA000;
        default: cp = $urandom_range('h4E00, 'h9FFF);
      endcase
      push_cjk(cp);
    end else if (pick < 68) begin
      text_bytes.push_back(8'($urandom_range('hC0, 'hDF)));
      text_bytes.push_back(8'($urandom_range('h80, 'hBF)));
    end else if (pick < 74) begin
      push_cjk($urandom_range('h800, 'hFFFF));
    end else if (pick < 80) begin
      text_bytes.push_back(8'($urandom_range('hF0, 'hF7)));
      repeat (3) text_bytes.push_back(8'($urandom_range('h80, 'hBF)));
    end else if (pick < 86) begin
      // Following bytes are not checked to be continuation bytes.
      lead = 8'($urandom_range('hC0, 'hF7));
      n = seq_bytes(lead);
      text_bytes.push_back(lead);
      repeat (n - 1) text_bytes.push_back(8'($urandom_range(1, 255)));
    end else if (pick < 92) begin
      // A sequence cut short.
      lead = 8'($urandom_range('hC2, 'hF4));
      n = seq_bytes(lead);
      text_bytes.push_back(lead);
      repeat ($urandom_range(0, n - 2)) text_bytes.push_back(8'($urandom_range('h80, 'hBF)));
    end else begin
      text_bytes.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic make_text(input int tokens);
    text_bytes.delete();
    repeat (tokens) add_token();
  endtask

  // Extremes of the byte, every class of sequence, skipped leads and a text cut short.
  task automatic test_directed();
    send_idle = 0;
    recv_stall = 0;
    send_byte(8'h00, 1'b0);
    text_bytes = '{8'h41, 8'h7A, 8'h30, 8'h39, 8'h20, 8'h7E};
    send_text(1'b0);
    text_bytes = '{8'hE4, 8'hB8, 8'hAD, 8'h80, 8'hFF, 8'hF0, 8'h9F, 8'h98, 8'h80,
                   8'hC3, 8'hA9, 8'hE9, 8'hBF, 8'hBF};
    send_text(1'b0);
    text_bytes = '{8'hE4, 8'h41};
    send_text(1'b0);
    send_byte(8'h7F, 1'b1);
    send_byte(8'h00, 1'b1);
  endtask

  // Hold the receiver off while the sender keeps offering, so the input stalls.
  task automatic test_backpressure();
    send_idle = 0;
    recv_stall = 0;
    write_capacity(16'd512);
    hold_asked++;
    text_bytes.delete();
    repeat (24) text_bytes.push_back(8'('h61 + $urandom_range(0, 25)));
    send_text(1'b0);
    wait_idle();
  endtask

  // Small capacities exercise the full buffer and sequences that do not fit.
  task automatic test_capacity_sweep();
    logic [15:0] caps [8];
    int          sent;
    caps = '{16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd5, 16'd7, 16'd65535};
    send_idle = 26;
    recv_stall = 26;
    foreach (caps[k]) begin
      write_capacity(caps[k]);
      sent = 0;
      while (sent < 6) begin
        make_text($urandom_range(1, 4));
        sent += text_bytes.size();
        send_text($urandom_range(0, 4) == 0);
      end
    end
  endtask

  // Random texts under each idling pattern.
  task automatic test_random_phases();
    int          idles [4];
    int          stalls [4];
    logic [15:0] caps [4];
    int          sent;
    idles  = '{0, 74, 0, 26};
    stalls = '{0, 0, 74, 26};
    caps   = '{16'd512, 16'd24, 16'd65535, 16'd9};
    for (int p = 0; p < 4; p++) begin
      write_capacity(caps[p]);
      send_idle = idles[p];
      recv_stall = stalls[p];
      sent = 0;
      while (sent < 25) begin
        make_text($urandom_range(1, 6));
        sent += text_bytes.size();
        send_text($urandom_range(0, 4) == 0);
      end
    end
  endtask

  // Receiver: random stalls, or a long hold-off when one is requested.
  always @(posedge clk) begin
    if (hold_asked != hold_served) begin
      hold_served = hold_asked;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(0, 99) >= recv_stall);
    end
  end

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      seen_result.data = out_if.out_byte;
      seen_result.has_byte = out_if.has_byte;
      seen_result.eot = out_if.end_of_text;
      if (due_results.size() == 0) begin
        mismatches++;
        $display("%0t: result with none expected: actual out_byte %h has_byte %b end_of_text %b",
                 $time, seen_result.data, seen_result.has_byte, seen_result.eot);
      end else begin
        due_result = due_results.pop_front();
        if (seen_result.data !== due_result.data) begin
          mismatches++;
          $display("%0t: out_byte expected %h actual %h", $time, due_result.data,
                   seen_result.data);
        end
        if (seen_result.has_byte !== due_result.has_byte) begin
          mismatches++;
          $display("%0t: has_byte expected %b actual %b", $time, due_result.has_byte,
                   seen_result.has_byte);
        end
        if (seen_result.eot !== due_result.eot) begin
          mismatches++;
          $display("%0t: end_of_text expected %b actual %b", $time, due_result.eot,
                   seen_result.eot);
        end
      end
    end
  end

  // Test sequence.
  initial begin
    int waited;
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.in_byte = 8'h00;
    in_if.in_last = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.output_capacity = 16'd0;
    out_if.ready = 1'b0;
    send_idle = 0;
    recv_stall = 0;
    hold_asked = 0;
    hold_served = 0;
    hold_left = 0;
    mismatches = 0;
    capacity = utf8tf_pkg::CAP_RESET;
    held[0] = 8'h00;
    held[1] = 8'h00;
    held[2] = 8'h00;
    held_n = 0;
    written = 0;
    text_full = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_backpressure();
    test_capacity_sweep();
    test_random_phases();

    // Drain what is still in flight, with a bound of its own.
    in_if.valid <= 1'b0;
    waited = 0;
    while (due_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (due_results.size() != 0) begin
      mismatches++;
      $display("%0t: %0d expected results never arrived", $time, due_results.size());
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("utf8_text_filter_core_tb OK");
    end else begin
      $display("utf8_text_filter_core_tb NOT OK");
    end
    $finish;
  end

  // Run limit.
  initial begin
    #2000000;
    $display("utf8_text_filter_core_tb NOT OK");
    $finish;
  end

endmodule
